@@ rtl/fti_pkg.sv @@
// Package for the fuzzy threat inference pipeline: grade types, membership
// tables, constant-divisor helpers and configuration register indexes.
// No dependencies.
`default_nettype none

package fti_pkg;

   localparam int GRADE_W   = 17;
   localparam int CRISP_W   = 16;
   localparam int CENT_W    = 6;
   localparam int COUNT_W   = 6;
   localparam int DIST_W    = 12;
   localparam int TERM_W    = 10;
   localparam int RECIP_W   = 25;
   localparam int NUM_W     = 24;
   localparam int SUM_W     = 18;
   localparam int DIV_STAGES    = 8;
   localparam int DIV_STEP_BITS = 2;

   typedef logic [GRADE_W-1:0] grade_type;

   localparam grade_type GRADE_ONE = GRADE_W'(65536);

   localparam logic [CENT_W-1:0] CENTROID_LOW_RESET    = CENT_W'(10);
   localparam logic [CENT_W-1:0] CENTROID_MEDIUM_RESET = CENT_W'(30);
   localparam logic [CENT_W-1:0] CENTROID_HIGH_RESET   = CENT_W'(50);

   localparam logic [1:0] CSR_CENTROID_LOW    = 2'd0;
   localparam logic [1:0] CSR_CENTROID_MEDIUM = 2'd1;
   localparam logic [1:0] CSR_CENTROID_HIGH   = 2'd2;

   typedef enum logic [1:0] {TERM_ZERO, TERM_ONE, TERM_DIV} term_kind_type;
   typedef enum logic [1:0] {DIV_200, DIV_300, DIV_500, DIV_800} div_sel_type;

   // one distance membership before its slope quotient is formed
   typedef struct packed {
      term_kind_type     kind;
      div_sel_type       sel;
      logic [TERM_W-1:0] num;
   } dist_term_type;

   // word that rides along the divider
   typedef struct packed {
      grade_type low;
      grade_type med;
      grade_type high;
      logic      none;
   } result_tag_type;

   // floor(2^32 / divisor)
   function automatic logic [RECIP_W-1:0] recip(input div_sel_type sel);
      unique case (sel)
         DIV_200: recip = RECIP_W'(21474836);
         DIV_300: recip = RECIP_W'(14316557);
         DIV_500: recip = RECIP_W'(8589934);
         DIV_800: recip = RECIP_W'(5368709);
         default: recip = '0;
      endcase
   endfunction

   function automatic logic [TERM_W-1:0] divisor(input div_sel_type sel);
      unique case (sel)
         DIV_200: divisor = TERM_W'(200);
         DIV_300: divisor = TERM_W'(300);
         DIV_500: divisor = TERM_W'(500);
         DIV_800: divisor = TERM_W'(800);
         default: divisor = '0;
      endcase
   endfunction

   // count sets: triangle 0,1,7
   function automatic grade_type count_tiny(input logic [COUNT_W-1:0] n);
      unique case (n)
         6'd1:    count_tiny = GRADE_ONE;
         6'd2:    count_tiny = GRADE_W'(54613);
         6'd3:    count_tiny = GRADE_W'(43690);
         6'd4:    count_tiny = GRADE_W'(32768);
         6'd5:    count_tiny = GRADE_W'(21845);
         6'd6:    count_tiny = GRADE_W'(10922);
         default: count_tiny = '0;
      endcase
   endfunction

   // trapezoid 6,8,10,12
   function automatic grade_type count_small(input logic [COUNT_W-1:0] n);
      unique case (n)
         6'd7, 6'd11:       count_small = GRADE_W'(32768);
         6'd8, 6'd9, 6'd10: count_small = GRADE_ONE;
         default:           count_small = '0;
      endcase
   endfunction

   // trapezoid 11,13,15,17
   function automatic grade_type count_moderate(input logic [COUNT_W-1:0] n);
      unique case (n)
         6'd12, 6'd16:        count_moderate = GRADE_W'(32768);
         6'd13, 6'd14, 6'd15: count_moderate = GRADE_ONE;
         default:             count_moderate = '0;
      endcase
   endfunction

   // ramp 16,19
   function automatic grade_type count_large(input logic [COUNT_W-1:0] n);
      if (n <= 6'd16) begin
         count_large = '0;
      end else if (n == 6'd17) begin
         count_large = GRADE_W'(21845);
      end else if (n == 6'd18) begin
         count_large = GRADE_W'(43690);
      end else begin
         count_large = GRADE_ONE;
      end
   endfunction

   function automatic grade_type gmin(input grade_type a, input grade_type b);
      gmin = (a < b) ? a : b;
   endfunction

   function automatic grade_type gmax(input grade_type a, input grade_type b);
      gmax = (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fti_divider.sv @@
// Pipelined restoring divider for the centroid average, two quotient bits
// per stage, with a tag word carried alongside. Depends on fti_pkg.
`default_nettype none

module fti_divider
   import fti_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NUM_W-1:0]     in_num,
   input  wire logic [SUM_W-1:0]     in_den,
   input  wire result_tag_type       in_tag,
   output logic                      out_valid,
   output logic [CRISP_W-1:0]        out_quot,
   output result_tag_type            out_tag
);

   logic                 valid_ff [DIV_STAGES+1];
   logic                 valid_in [DIV_STAGES+1];
   logic [SUM_W-1:0]     rem_ff   [DIV_STAGES+1];
   logic [SUM_W-1:0]     rem_in   [DIV_STAGES+1];
   logic [CRISP_W-1:0]   low_ff   [DIV_STAGES+1];
   logic [CRISP_W-1:0]   low_in   [DIV_STAGES+1];
   logic [CRISP_W-1:0]   quot_ff  [DIV_STAGES+1];
   logic [CRISP_W-1:0]   quot_in  [DIV_STAGES+1];
   logic [SUM_W-1:0]     den_ff   [DIV_STAGES+1];
   logic [SUM_W-1:0]     den_in   [DIV_STAGES+1];
   result_tag_type       tag_ff   [DIV_STAGES+1];
   result_tag_type       tag_in   [DIV_STAGES+1];

   // load: dividend is num << 10; its top bits are already below the divisor
   // since the quotient fits 16 bits
   always_comb begin
      logic [SUM_W-1:0]   rem;
      logic [CRISP_W-1:0] low;
      logic [CRISP_W-1:0] quo;
      logic [SUM_W:0]     trial;
      valid_in[0] = in_valid;
      rem_in[0]   = in_num[NUM_W-1:6];
      low_in[0]   = {in_num[5:0], 10'b0};
      quot_in[0]  = '0;
      den_in[0]   = in_den;
      tag_in[0]   = in_tag;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem = rem_ff[s];
         low = low_ff[s];
         quo = quot_ff[s];
         for (int b = 0; b < DIV_STEP_BITS; b++) begin
            trial = {rem, low[CRISP_W-1]};
            low   = {low[CRISP_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff[s]}) begin
               rem = SUM_W'(trial - {1'b0, den_ff[s]});
               quo = {quo[CRISP_W-2:0], 1'b1};
            end else begin
               rem = trial[SUM_W-1:0];
               quo = {quo[CRISP_W-2:0], 1'b0};
            end
         end
         valid_in[s+1] = valid_ff[s];
         rem_in[s+1]   = rem;
         low_in[s+1]   = low;
         quot_in[s+1]  = quo;
         den_in[s+1]   = den_ff[s];
         tag_in[s+1]   = tag_ff[s];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         rem_ff[s]  <= rem_in[s];
         low_ff[s]  <= low_in[s];
         quot_ff[s] <= quot_in[s];
         den_ff[s]  <= den_in[s];
         tag_ff[s]  <= tag_in[s];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign out_quot  = quot_ff[DIV_STAGES];
   assign out_tag   = tag_ff[DIV_STAGES];

   // partial remainder stays below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && den_ff[0] != '0 |-> rem_ff[0] < den_ff[0])
      else $error("divider remainder out of range");

   a_rem_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && den_ff[DIV_STAGES] != '0 |-> rem_ff[DIV_STAGES] < den_ff[DIV_STAGES])
      else $error("divider final remainder out of range");

   a_none_den: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_tag.none == (den_ff[DIV_STAGES] == '0)))
      else $error("no-activation flag disagrees with divisor");

endmodule

`default_nettype wire

@@ rtl/fuzzy_threat_inference.sv @@
// Top level of the fuzzy threat inference pipeline: fuzzification, rule
// base, centroid weighting and defuzzification. Depends on fti_pkg, fti_divider.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------------
//   request | start, busy, req_item_count, req_distance | word taken: start && !busy
//   result  | rsp_strobe, rsp_* fields                | one cycle, receiver can't stall
//   config  | csr_write_enable, csr_index, csr_write_data | written when enable high
//
// One word enters per cycle while busy is low; after its word is taken, each
// result passes 4 fuzzify/rule stages, 1 divider load and 8 divider stages.
// Most of that depth comes from the 2-bit-per-stage restoring divider.
// Reset is synchronous: it flushes all valid bits, restores the centroids and
// holds busy high. Results cannot be stalled, so nothing ever backs up.
`default_nettype none

module fuzzy_threat_inference
   import fti_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [COUNT_W-1:0]  req_item_count,
   input  wire logic [DIST_W-1:0]   req_distance,
   output logic                     rsp_strobe,
   output logic [GRADE_W-1:0]       rsp_low_grade,
   output logic [GRADE_W-1:0]       rsp_medium_grade,
   output logic [GRADE_W-1:0]       rsp_high_grade,
   output logic [CRISP_W-1:0]       rsp_crisp_level,
   output logic                     rsp_no_activation,
   input  wire logic                csr_write_enable,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CENT_W-1:0]   csr_write_data
);

   logic [CENT_W-1:0] cent_low_ff, cent_med_ff, cent_high_ff;

   logic          accept;
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   grade_type     s1_count_ff [4];
   grade_type     s2_count_ff [4];
   grade_type     s3_count_ff [4];
   dist_term_type s1_term_in  [3];
   dist_term_type s1_term_ff  [3];
   dist_term_type s2_term_ff  [3];
   logic [GRADE_W-1:0] s2_q0_in [3];
   logic [GRADE_W-1:0] s2_q0_ff [3];
   grade_type     s3_dist_in  [3];
   grade_type     s3_dist_ff  [3];
   grade_type     s4_low_in, s4_med_in, s4_high_in;
   grade_type     s4_low_ff, s4_med_ff, s4_high_ff;

   logic [NUM_W-1:0] div_num;
   logic [SUM_W-1:0] div_den;
   result_tag_type   div_tag;
   logic             out_valid;
   logic [CRISP_W-1:0] out_quot;
   result_tag_type   out_tag;

   assign busy   = reset;
   assign accept = start && !busy;

   // centroid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cent_low_ff  <= CENTROID_LOW_RESET;
         cent_med_ff  <= CENTROID_MEDIUM_RESET;
         cent_high_ff <= CENTROID_HIGH_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CENTROID_LOW)    cent_low_ff  <= csr_write_data;
         if (csr_index == CSR_CENTROID_MEDIUM) cent_med_ff  <= csr_write_data;
         if (csr_index == CSR_CENTROID_HIGH)   cent_high_ff <= csr_write_data;
      end
   end

   // stage 1: distance region decode (close, medium, far)
   always_comb begin
      logic [DIST_W-1:0] d;
      d = req_distance;
      // close: triangle 0,500,1300
      s1_term_in[0].num = '0;
      if (d == '0 || d >= DIST_W'(1300)) begin
         s1_term_in[0].kind = TERM_ZERO;
         s1_term_in[0].sel  = DIV_500;
      end else if (d == DIST_W'(500)) begin
         s1_term_in[0].kind = TERM_ONE;
         s1_term_in[0].sel  = DIV_500;
      end else if (d < DIST_W'(500)) begin
         s1_term_in[0].kind = TERM_DIV;
         s1_term_in[0].sel  = DIV_500;
         s1_term_in[0].num  = d[TERM_W-1:0];
      end else begin
         s1_term_in[0].kind = TERM_DIV;
         s1_term_in[0].sel  = DIV_800;
         s1_term_in[0].num  = TERM_W'(DIST_W'(1300) - d);
      end
      // medium: trapezoid 1150,1350,1900,2100
      s1_term_in[1].num = '0;
      s1_term_in[1].sel = DIV_200;
      if (d <= DIST_W'(1150) || d >= DIST_W'(2100)) begin
         s1_term_in[1].kind = TERM_ZERO;
      end else if (d >= DIST_W'(1350) && d <= DIST_W'(1900)) begin
         s1_term_in[1].kind = TERM_ONE;
      end else if (d < DIST_W'(1350)) begin
         s1_term_in[1].kind = TERM_DIV;
         s1_term_in[1].num  = TERM_W'(d - DIST_W'(1150));
      end else begin
         s1_term_in[1].kind = TERM_DIV;
         s1_term_in[1].num  = TERM_W'(DIST_W'(2100) - d);
      end
      // far: ramp 1950,2250
      s1_term_in[2].num = '0;
      s1_term_in[2].sel = DIV_300;
      if (d <= DIST_W'(1950)) begin
         s1_term_in[2].kind = TERM_ZERO;
      end else if (d > DIST_W'(2250)) begin
         s1_term_in[2].kind = TERM_ONE;
      end else begin
         s1_term_in[2].kind = TERM_DIV;
         s1_term_in[2].num  = TERM_W'(d - DIST_W'(1950));
      end
   end

   // stage 2: reciprocal estimate, may be one low
   always_comb begin
      logic [TERM_W+RECIP_W-1:0] prod;
      for (int i = 0; i < 3; i++) begin
         prod = (TERM_W+RECIP_W)'(s1_term_ff[i].num) *
                (TERM_W+RECIP_W)'(recip(s1_term_ff[i].sel));
         s2_q0_in[i] = prod[GRADE_W+15:16];
      end
   end

   // stage 3: one correction step, then resolve zero/one cases
   always_comb begin
      logic [TERM_W+16:0] v;
      logic [TERM_W+16:0] qd;
      logic [TERM_W+16:0] r;
      for (int i = 0; i < 3; i++) begin
         v  = {1'b0, s2_term_ff[i].num, 16'b0};
         qd = (TERM_W+17)'(s2_q0_ff[i]) * (TERM_W+17)'(divisor(s2_term_ff[i].sel));
         r  = v - qd;
         unique case (s2_term_ff[i].kind)
            TERM_ONE: s3_dist_in[i] = GRADE_ONE;
            TERM_DIV: begin
               if (r >= (TERM_W+17)'(divisor(s2_term_ff[i].sel))) begin
                  s3_dist_in[i] = s2_q0_ff[i] + GRADE_W'(1);
               end else begin
                  s3_dist_in[i] = s2_q0_ff[i];
               end
            end
            default: s3_dist_in[i] = '0;
         endcase
      end
   end

   // stage 4: rule base; count order tiny, small, moderate, large
   always_comb begin
      s4_low_in = gmax(gmax(gmin(s3_dist_ff[1], s3_count_ff[0]),
                            gmin(s3_dist_ff[1], s3_count_ff[1])),
                       gmin(s3_dist_ff[2], GRADE_ONE - s3_count_ff[3]));
      s4_med_in = gmax(gmax(gmin(s3_dist_ff[0], s3_count_ff[0]),
                            gmin(s3_dist_ff[1], s3_count_ff[2])),
                       gmin(s3_dist_ff[2], s3_count_ff[3]));
      s4_high_in = gmax(gmin(s3_dist_ff[0], GRADE_ONE - s3_count_ff[0]),
                        gmin(s3_dist_ff[1], s3_count_ff[3]));
   end

   // front pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_count_ff[0] <= count_tiny(req_item_count);
      s1_count_ff[1] <= count_small(req_item_count);
      s1_count_ff[2] <= count_moderate(req_item_count);
      s1_count_ff[3] <= count_large(req_item_count);
      for (int i = 0; i < 4; i++) begin
         s2_count_ff[i] <= s1_count_ff[i];
         s3_count_ff[i] <= s2_count_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         s1_term_ff[i] <= s1_term_in[i];
         s2_term_ff[i] <= s1_term_ff[i];
         s2_q0_ff[i]   <= s2_q0_in[i];
         s3_dist_ff[i] <= s3_dist_in[i];
      end
      s4_low_ff  <= s4_low_in;
      s4_med_ff  <= s4_med_in;
      s4_high_ff <= s4_high_in;
   end

   // weighted centroid sum and grade sum into the divider
   always_comb begin
      div_num = NUM_W'(s4_low_ff) * NUM_W'(cent_low_ff)
              + NUM_W'(s4_med_ff) * NUM_W'(cent_med_ff)
              + NUM_W'(s4_high_ff) * NUM_W'(cent_high_ff);
      div_den = SUM_W'(s4_low_ff) + SUM_W'(s4_med_ff) + SUM_W'(s4_high_ff);
      div_tag.low    = s4_low_ff;
      div_tag.med    = s4_med_ff;
      div_tag.high   = s4_high_ff;
      div_tag.none   = (div_den == '0);
   end

   fti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_tag    (div_tag),
      .out_valid (out_valid),
      .out_quot  (out_quot),
      .out_tag   (out_tag)
   );

   // result word
   assign rsp_strobe        = out_valid;
   assign rsp_low_grade     = out_tag.low;
   assign rsp_medium_grade  = out_tag.med;
   assign rsp_high_grade    = out_tag.high;
   assign rsp_no_activation = out_tag.none;
   assign rsp_crisp_level   = out_tag.none ? '0 : out_quot;

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_no_activation |->
         rsp_low_grade == '0 && rsp_medium_grade == '0 && rsp_high_grade == '0)
      else $error("no activation with a nonzero grade");

   a_crisp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_crisp_level <= CRISP_W'(64512))
      else $error("crisp level above top centroid");

   a_grade_bound: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s4_low_ff <= GRADE_ONE && s4_med_ff <= GRADE_ONE &&
                      s4_high_ff <= GRADE_ONE)
      else $error("rule grade above one");

endmodule

`default_nettype wire

@@ dv/fti_checker.sv @@
// Checker for fuzzy_threat_inference: predicts each result word from the
// accepted request words and the centroid writes, and compares. Uses fti_pkg.
`default_nettype none

module fti_checker
   import fti_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [COUNT_W-1:0]  req_item_count,
   input  wire logic [DIST_W-1:0]   req_distance,
   input  wire logic                rsp_strobe,
   input  wire logic [GRADE_W-1:0]  rsp_low_grade,
   input  wire logic [GRADE_W-1:0]  rsp_medium_grade,
   input  wire logic [GRADE_W-1:0]  rsp_high_grade,
   input  wire logic [CRISP_W-1:0]  rsp_crisp_level,
   input  wire logic                rsp_no_activation,
   input  wire logic                csr_write_enable,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CENT_W-1:0]   csr_write_data,
   output int                       fail_count,
   output int                       pending_count
);

   localparam longint ONE = 64'd65536;

   typedef struct packed {
      logic [GRADE_W-1:0] low;
      logic [GRADE_W-1:0] med;
      logic [GRADE_W-1:0] high;
      logic [CRISP_W-1:0] crisp;
      logic               none;
   } threat_word_type;

   threat_word_type threat_queue[$];
   longint cent_low, cent_medium, cent_high;

   function automatic longint slope_up(longint x, longint a, longint b);
      return ((x - a) * ONE) / (b - a);
   endfunction

   function automatic longint slope_down(longint x, longint c, longint d);
      return ((d - x) * ONE) / (d - c);
   endfunction

   function automatic longint ramp(longint x, longint a, longint b);
      if (x <= a) return 0;
      if (x > b) return ONE;
      return slope_up(x, a, b);
   endfunction

   function automatic longint tri_mf(longint x, longint a, longint b, longint c);
      if (x <= a || x >= c) return 0;
      if (x == b) return ONE;
      if (x < b) return slope_up(x, a, b);
      return slope_down(x, b, c);
   endfunction

   function automatic longint trap(longint x, longint a, longint b, longint c,
                                   longint d);
      if (x <= a || x >= d) return 0;
      if (x >= b && x <= c) return ONE;
      if (x < b) return slope_up(x, a, b);
      return slope_down(x, c, d);
   endfunction

   function automatic longint mn(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint mx(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic threat_word_type assess_threat(longint n, longint d);
      threat_word_type w;
      longint tiny, sml, moder, lrg, near, mid, far, gl, gm, gh, total;
      tiny  = tri_mf(n, 0, 1, 7);
      sml   = trap(n, 6, 8, 10, 12);
      moder = trap(n, 11, 13, 15, 17);
      lrg   = ramp(n, 16, 19);
      near  = tri_mf(d, 0, 500, 1300);
      mid   = trap(d, 1150, 1350, 1900, 2100);
      far   = ramp(d, 1950, 2250);
      gl = mx(mx(mn(mid, tiny), mn(mid, sml)), mn(far, ONE - lrg));
      gm = mx(mx(mn(near, tiny), mn(mid, moder)), mn(far, lrg));
      gh = mx(mn(near, ONE - tiny), mn(mid, lrg));
      total = gl + gm + gh;
      w.low = gl[GRADE_W-1:0];
      w.med = gm[GRADE_W-1:0];
      w.high = gh[GRADE_W-1:0];
      w.none = (total == 0);
      w.crisp = '0;
      if (total != 0)
         w.crisp = CRISP_W'(((gl * cent_low + gm * cent_medium + gh * cent_high)
                             * 1024) / total);
      return w;
   endfunction

   assign pending_count = threat_queue.size();

   always @(posedge clock) begin
      threat_word_type got, want;
      if (reset) begin
         cent_low    <= CENTROID_LOW_RESET;
         cent_medium <= CENTROID_MEDIUM_RESET;
         cent_high   <= CENTROID_HIGH_RESET;
         threat_queue.delete();
         fail_count  <= 0;
      end else begin
         // result side first: an accepted word predicted this edge is not due yet
         if (rsp_strobe) begin
            got = '{rsp_low_grade, rsp_medium_grade, rsp_high_grade,
                    rsp_crisp_level, rsp_no_activation};
            if (threat_queue.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = threat_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected low %0d med %0d high %0d crisp %0d none %0d",
                           $time, want.low, want.med, want.high, want.crisp, want.none);
                  $display("%0t:          actual   low %0d med %0d high %0d crisp %0d none %0d",
                           $time, got.low, got.med, got.high, got.crisp, got.none);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            threat_queue.insert(threat_queue.size(),
                                assess_threat(req_item_count, req_distance));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CENTROID_LOW:    cent_low    <= csr_write_data;
               CSR_CENTROID_MEDIUM: cent_medium <= csr_write_data;
               CSR_CENTROID_HIGH:   cent_high   <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench top for fuzzy_threat_inference: clock, reset, request and
// centroid stimulus, verdict. Depends on fti_pkg, the RTL and fti_checker.
`default_nettype none

module tb;
   import fti_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [COUNT_W-1:0] req_item_count = '0;
   logic [DIST_W-1:0]  req_distance = '0;
   logic rsp_strobe, rsp_no_activation;
   logic [GRADE_W-1:0] rsp_low_grade, rsp_medium_grade, rsp_high_grade;
   logic [CRISP_W-1:0] rsp_crisp_level;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_CENTROID_LOW;
   logic [CENT_W-1:0] csr_write_data = '0;
   int fail_count, pending_count;

   localparam int LATENCY = 13;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fuzzy_threat_inference DUT (.*);

   fti_checker checker_inst (.*);

   // send one word; unless told not to, first idle at random, going on idling with a chance of 22 in 100 at each try
   task automatic send_word(input logic [COUNT_W-1:0] n, input logic [DIST_W-1:0] d,
                            input bit gaps);
      while (gaps && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item_count <= n;
      req_distance <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_centroids(input logic [CENT_W-1:0] lo, input logic [CENT_W-1:0] me,
                                input logic [CENT_W-1:0] hi);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CENTROID_LOW;    csr_write_data <= lo; @(posedge clock);
      csr_index <= CSR_CENTROID_MEDIUM; csr_write_data <= me; @(posedge clock);
      csr_index <= CSR_CENTROID_HIGH;   csr_write_data <= hi; @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random counts and distances, three in four within the span of the membership sets
   function automatic logic [COUNT_W-1:0] pick_count;
      int sel;
      sel = $urandom_range(3);
      if (sel == 0) return COUNT_W'($urandom);
      return COUNT_W'($urandom_range(20));
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance;
      int sel;
      sel = $urandom_range(3);
      if (sel == 0) return DIST_W'($urandom);
      return DIST_W'($urandom_range(2400));
   endfunction

   initial begin
      #400000;
      $display("[fuzzy_threat_inference] ERROR");
      $finish;
   end

   initial begin
      int phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: set corners, apexes, ramps, no-activation, field extremes
      send_word(0, 0, 0);      send_word(1, 500, 0);   send_word(7, 1300, 0);
      send_word(63, 4095, 0);  send_word(9, 1600, 0);  send_word(14, 1600, 0);
      send_word(18, 2000, 0);  send_word(19, 2250, 0); send_word(17, 2251, 0);
      send_word(12, 1150, 0);  send_word(11, 1350, 0); send_word(16, 2100, 0);
      send_word(6, 1900, 0);   send_word(8, 1950, 0);  send_word(2, 1200, 0);
      send_word(20, 1000, 0);  send_word(3, 0, 0);     send_word(42, 2730, 0);
      send_word(21, 1365, 0);  send_word(0, 1600, 0);
      drain();
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_centroids(0, 0, 0);
            1: set_centroids(63, 63, 63);
            2: set_centroids(63, 0, 42);
            3: set_centroids(CENT_W'($urandom), CENT_W'($urandom), CENT_W'($urandom));
            4: set_centroids(21, 0, 63);
            default: set_centroids(10, 30, 50);
         endcase
         repeat (220) send_word(pick_count(), pick_distance(), phase != 2);
         drain();   // sender waits for all results before the centroids change
      end
      drain();
      if (fail_count == 0) begin
         $display("[fuzzy_threat_inference] OK");
      end else begin
         $display("[fuzzy_threat_inference] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
